/* rtl/core/s7ff_pkg.sv */
// ----------------------------------------------------------------------------
// s7ff_pkg
// Shared widths, header positions and match values for the S7comm frame
// filter.
// ----------------------------------------------------------------------------
`default_nettype none

package s7ff_pkg;

  // capture limit: bytes at or past this position are not examined
  localparam int unsigned MAX_FRAME_BYTES = 16384;

  // byte counter saturates at POS_MAX
  localparam int unsigned POS_W   = 15;
  localparam int unsigned POS_MAX = (1 << POS_W) - 1;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned TCP_START_W = 7;
  localparam int unsigned HDR_END_W   = 8;
  localparam int unsigned S7_OFF_W    = 9;
  localparam int unsigned NIB_W       = 4;

  // fixed frame positions
  localparam int unsigned ETYPE_HI_POS  = 12;
  localparam int unsigned ETYPE_LO_POS  = 13;
  localparam int unsigned IHL_POS       = 14;
  localparam int unsigned IP_PROTO_POS  = 23;
  localparam int unsigned ETH_HDR_BYTES = 14;

  // offsets relative to header starts
  localparam int unsigned TCP_DOFF_OFS  = 12;
  localparam int unsigned COTP_LEN_OFS  = 4;
  localparam int unsigned S7_ID_OFS     = 5;
  localparam int unsigned S7_TYPE_OFS   = 1;
  localparam int unsigned S7_PLEN_HI_OFS = 6;
  localparam int unsigned S7_PLEN_LO_OFS = 7;
  localparam int unsigned S7_DLEN_HI_OFS = 8;
  localparam int unsigned S7_DLEN_LO_OFS = 9;

  // match values
  localparam logic [BYTE_W-1:0] ETYPE_HI     = 8'h08;
  localparam logic [BYTE_W-1:0] ETYPE_LO     = 8'h00;
  localparam logic [BYTE_W-1:0] IP_PROTO_TCP = 8'h06;
  localparam logic [BYTE_W-1:0] TPKT_VERSION = 8'h03;
  localparam logic [BYTE_W-1:0] COTP_DT_FLAG = 8'h80;
  localparam logic [BYTE_W-1:0] S7_PROTO_ID  = 8'h32;
  localparam logic [NIB_W-1:0]  MIN_HDR_WORDS = 4'd5;

endpackage

`default_nettype wire

/* rtl/core/s7ff_in_if.sv */
// ----------------------------------------------------------------------------
// s7ff_in_if
// Frame byte channel: one frame byte per word, with an end-of-frame mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface s7ff_in_if;
  logic                           valid;
  logic                           ready;
  logic [s7ff_pkg::BYTE_W-1:0]    frame_byte;
  logic                           last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

`default_nettype wire

/* rtl/core/s7ff_out_if.sv */
// ----------------------------------------------------------------------------
// s7ff_out_if
// Verdict channel: one word per frame with the keep flag and S7 header fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface s7ff_out_if;
  logic                            valid;
  logic                            ready;
  logic                            keep_frame;
  logic [s7ff_pkg::BYTE_W-1:0]     message_type;
  logic [s7ff_pkg::LEN_W-1:0]      parameter_length;
  logic [s7ff_pkg::LEN_W-1:0]      data_length;
  logic [s7ff_pkg::S7_OFF_W-1:0]   s7_start_offset;

  modport source (output valid, output keep_frame, output message_type,
                  output parameter_length, output data_length,
                  output s7_start_offset, input ready);
  modport sink   (input valid, input keep_frame, input message_type,
                  input parameter_length, input data_length,
                  input s7_start_offset, output ready);
endinterface

`default_nettype wire

/* rtl/core/s7comm_frame_filter_unit.sv */
// ----------------------------------------------------------------------------
// s7comm_frame_filter_unit
// Byte-serial Ethernet/IPv4/TCP/TPKT/COTP/S7comm frame classifier.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle from in_chan and, on the byte marked last,
// emits one verdict word on out_chan: keep flag, S7 ROSCTR, parameter and
// data lengths and the frame position of the S7 protocol id (all zero when
// the frame is dropped). A byte is registered on entry and examined against
// the header state kept so far as it leaves the input register, and the
// verdict word is registered when the last byte is examined. Throughput is
// one byte per cycle; in_chan.ready drops only while a last byte waits in
// the input register for the verdict register, still held by out_chan, to
// be taken. Bytes at or beyond MAX_FRAME_BYTES are counted but not examined.
// ----------------------------------------------------------------------------
`default_nettype none

module s7comm_frame_filter_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  s7ff_in_if.sink    in_chan,
  s7ff_out_if.source out_chan
);
  import s7ff_pkg::*;

  // input register
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;
  logic              s1_adv;
  logic              s1_fire;

  // per-frame state
  logic [POS_W-1:0]       pos_r,       pos_nxt;
  logic [TCP_START_W-1:0] tcp_start_r, tcp_start_nxt;
  logic [HDR_END_W-1:0]   hdr_end_r,   hdr_end_nxt;
  logic [BYTE_W-1:0]      cotp_len_r,  cotp_len_nxt;
  logic                   match_r,     match_nxt;
  logic                   s7_seen_r,   s7_seen_nxt;
  logic [BYTE_W-1:0]      type_r,      type_nxt;
  logic [LEN_W-1:0]       plen_r,      plen_nxt;
  logic [LEN_W-1:0]       dlen_r,      dlen_nxt;

  // verdict register
  logic                out_valid_r;
  logic                keep_r;
  logic [BYTE_W-1:0]   msg_type_r;
  logic [LEN_W-1:0]    par_len_r;
  logic [LEN_W-1:0]    dat_len_r;
  logic [S7_OFF_W-1:0] s7_off_out_r;

  logic [S7_OFF_W-1:0] s7_off;
  logic [S7_OFF_W-1:0] s7_off_fin;
  logic [BYTE_W-1:0]   type_fin;
  logic [LEN_W-1:0]    plen_fin;
  logic [LEN_W-1:0]    dlen_fin;
  logic [POS_W-1:0]    s7_pos;
  logic [NIB_W-1:0]    lo_nib;
  logic [NIB_W-1:0]    hi_nib;
  logic                examine_en;
  logic                keep_nxt;

  // a non-last byte always moves on; a last byte needs room in the verdict register
  assign s1_adv  = !s1_last_r || !out_valid_r || out_chan.ready;
  assign s1_fire = s1_valid_r && s1_adv;
  assign in_chan.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_byte_r <= in_chan.frame_byte;
      s1_last_r <= in_chan.last_byte;
    end
  end

  assign lo_nib     = s1_byte_r[NIB_W-1:0];
  assign hi_nib     = s1_byte_r[BYTE_W-1:NIB_W];
  assign s7_off     = S7_OFF_W'(hdr_end_r) + S7_OFF_W'(S7_ID_OFS) + S7_OFF_W'(cotp_len_r);
  assign s7_pos     = POS_W'(s7_off);
  assign examine_en = (32'(pos_r) < MAX_FRAME_BYTES) && match_r;

  always_comb begin
    pos_nxt       = pos_r;
    tcp_start_nxt = tcp_start_r;
    hdr_end_nxt   = hdr_end_r;
    cotp_len_nxt  = cotp_len_r;
    match_nxt     = match_r;
    s7_seen_nxt   = s7_seen_r;
    type_nxt      = type_r;
    plen_nxt      = plen_r;
    dlen_nxt      = dlen_r;
    keep_nxt      = 1'b0;
    s7_off_fin    = '0;
    type_fin      = '0;
    plen_fin      = '0;
    dlen_fin      = '0;

    if (s1_fire) begin
      if (examine_en) begin
        if (pos_r == POS_W'(ETYPE_HI_POS) && s1_byte_r != ETYPE_HI) begin
          match_nxt = 1'b0;
        end else if (pos_r == POS_W'(ETYPE_LO_POS) && s1_byte_r != ETYPE_LO) begin
          match_nxt = 1'b0;
        end else if (pos_r == POS_W'(IHL_POS)) begin
          if (lo_nib < MIN_HDR_WORDS) begin
            match_nxt = 1'b0;
          end else begin
            tcp_start_nxt = TCP_START_W'(ETH_HDR_BYTES) + TCP_START_W'({lo_nib, 2'b00});
          end
        end else if (pos_r == POS_W'(IP_PROTO_POS) && s1_byte_r != IP_PROTO_TCP) begin
          match_nxt = 1'b0;
        end else if (tcp_start_r != '0 &&
                     pos_r == POS_W'(tcp_start_r) + POS_W'(TCP_DOFF_OFS)) begin
          if (hi_nib < MIN_HDR_WORDS) begin
            match_nxt = 1'b0;
          end else begin
            hdr_end_nxt = HDR_END_W'(tcp_start_r) + HDR_END_W'({hi_nib, 2'b00});
          end
        end else if (hdr_end_r != '0) begin
          if (pos_r == POS_W'(hdr_end_r)) begin
            if (s1_byte_r != TPKT_VERSION) begin
              match_nxt = 1'b0;
            end
          end else if (pos_r == POS_W'(hdr_end_r) + POS_W'(COTP_LEN_OFS)) begin
            if (s1_byte_r == '0) begin
              match_nxt = 1'b0;
            end else begin
              cotp_len_nxt = s1_byte_r;
            end
          end else if (cotp_len_r != '0) begin
            // cotp flag byte sits just ahead of the s7 id
            if (pos_r == s7_pos - POS_W'(1)) begin
              if (s1_byte_r != COTP_DT_FLAG) begin
                match_nxt = 1'b0;
              end
            end else if (pos_r == s7_pos) begin
              if (s1_byte_r != S7_PROTO_ID) begin
                match_nxt = 1'b0;
              end else begin
                s7_seen_nxt = 1'b1;
              end
            end else if (s7_seen_r) begin
              if (pos_r == s7_pos + POS_W'(S7_TYPE_OFS)) begin
                type_nxt = s1_byte_r;
              end else if (pos_r == s7_pos + POS_W'(S7_PLEN_HI_OFS)) begin
                plen_nxt = {s1_byte_r, plen_r[BYTE_W-1:0]};
              end else if (pos_r == s7_pos + POS_W'(S7_PLEN_LO_OFS)) begin
                plen_nxt = {plen_r[LEN_W-1:BYTE_W], s1_byte_r};
              end else if (pos_r == s7_pos + POS_W'(S7_DLEN_HI_OFS)) begin
                dlen_nxt = {s1_byte_r, dlen_r[BYTE_W-1:0]};
              end else if (pos_r == s7_pos + POS_W'(S7_DLEN_LO_OFS)) begin
                dlen_nxt = {dlen_r[LEN_W-1:BYTE_W], s1_byte_r};
              end
            end
          end
        end
      end

      if (32'(pos_r) < POS_MAX) begin
        pos_nxt = pos_r + POS_W'(1);
      end

      if (s1_last_r) begin
        keep_nxt   = match_nxt && s7_seen_nxt;
        s7_off_fin = S7_OFF_W'(hdr_end_nxt) + S7_OFF_W'(S7_ID_OFS) + S7_OFF_W'(cotp_len_nxt);
        type_fin   = type_nxt;
        plen_fin   = plen_nxt;
        dlen_fin   = dlen_nxt;
        // back to the start-of-frame state
        pos_nxt       = '0;
        tcp_start_nxt = '0;
        hdr_end_nxt   = '0;
        cotp_len_nxt  = '0;
        match_nxt     = 1'b1;
        s7_seen_nxt   = 1'b0;
        type_nxt      = '0;
        plen_nxt      = '0;
        dlen_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      tcp_start_r <= '0;
      hdr_end_r   <= '0;
      cotp_len_r  <= '0;
      match_r     <= 1'b1;
      s7_seen_r   <= 1'b0;
      type_r      <= '0;
      plen_r      <= '0;
      dlen_r      <= '0;
    end else begin
      pos_r       <= pos_nxt;
      tcp_start_r <= tcp_start_nxt;
      hdr_end_r   <= hdr_end_nxt;
      cotp_len_r  <= cotp_len_nxt;
      match_r     <= match_nxt;
      s7_seen_r   <= s7_seen_nxt;
      type_r      <= type_nxt;
      plen_r      <= plen_nxt;
      dlen_r      <= dlen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // dropped frames report all-zero fields
  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      keep_r       <= keep_nxt;
      msg_type_r   <= keep_nxt ? type_fin : '0;
      par_len_r    <= keep_nxt ? plen_fin : '0;
      dat_len_r    <= keep_nxt ? dlen_fin : '0;
      s7_off_out_r <= keep_nxt ? s7_off_fin : '0;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.keep_frame       = keep_r;
  assign out_chan.message_type     = msg_type_r;
  assign out_chan.parameter_length = par_len_r;
  assign out_chan.data_length      = dat_len_r;
  assign out_chan.s7_start_offset  = s7_off_out_r;

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the S7comm frame filter: directed frame table, then
// random well-formed, broken and noise frames with random idle on both sides.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import s7ff_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int NUM_ROWS    = 24;
  localparam int RAND_BYTES  = 500;
  localparam int RAND_FRAMES = 8;

  typedef enum {
    FK_GOOD, FK_BAD_ETYPE_HI, FK_BAD_ETYPE_LO, FK_SHORT_IHL, FK_NOT_TCP,
    FK_SHORT_DOFF, FK_BAD_TPKT, FK_ZERO_COTP, FK_BAD_FLAG, FK_BAD_S7ID, FK_NOISE
  } frame_kind_t;

  typedef enum {FILL_RAND, FILL_ZERO, FILL_ONES} fill_t;

  typedef struct packed {
    logic                keep;
    logic [BYTE_W-1:0]   msg_type;
    logic [LEN_W-1:0]    param_len;
    logic [LEN_W-1:0]    dat_len;
    logic [S7_OFF_W-1:0] s7_off;
  } verdict_t;

  // cut: bytes kept from the s7 id on (-1 keeps all), cap: absolute length cap
  typedef struct {
    frame_kind_t kind;
    int          ihl;
    int          doff;
    int          cotp;
    int          pad;
    int          cut;
    int          cap;
    fill_t       fill;
    bit          drop;
  } frame_row_t;

  frame_row_t frame_rows [NUM_ROWS] = '{
    '{FK_NOISE,         5,  5,   1,     0, -1,  0, FILL_RAND, 1'b1},
    '{FK_GOOD,          5,  5,   1,     0, -1,  0, FILL_ZERO, 1'b0},
    '{FK_GOOD,         15, 15, 255,     4, -1,  0, FILL_ONES, 1'b0},
    '{FK_GOOD,          5,  5,   2,     3, -1,  0, FILL_RAND, 1'b0},
    '{FK_BAD_ETYPE_HI,  5,  5,   2,     0, -1,  0, FILL_RAND, 1'b1},
    '{FK_BAD_ETYPE_LO,  5,  5,   2,     0, -1,  0, FILL_RAND, 1'b1},
    '{FK_SHORT_IHL,     4,  5,   2,     0, -1,  0, FILL_RAND, 1'b1},
    '{FK_SHORT_IHL,     0,  5,   2,     0, -1,  0, FILL_RAND, 1'b1},
    '{FK_NOT_TCP,       5,  5,   2,     0, -1,  0, FILL_RAND, 1'b1},
    '{FK_SHORT_DOFF,    5,  4,   2,     0, -1,  0, FILL_RAND, 1'b1},
    '{FK_SHORT_DOFF,    5,  0,   2,     0, -1,  0, FILL_RAND, 1'b1},
    '{FK_BAD_TPKT,      5,  5,   2,     0, -1,  0, FILL_RAND, 1'b1},
    '{FK_ZERO_COTP,     5,  5,   2,     0, -1,  0, FILL_RAND, 1'b1},
    '{FK_BAD_FLAG,      5,  5,   2,     0, -1,  0, FILL_RAND, 1'b1},
    '{FK_BAD_S7ID,      5,  5,   2,     0, -1,  0, FILL_RAND, 1'b1},
    '{FK_GOOD,          6,  5,   2,     0,  0,  0, FILL_RAND, 1'b1},
    '{FK_GOOD,          5,  6,   2,     0,  1,  0, FILL_RAND, 1'b0},
    '{FK_GOOD,          5,  5,   3,     0,  2,  0, FILL_RAND, 1'b0},
    '{FK_GOOD,          5,  5,   2,     0,  7,  0, FILL_ONES, 1'b0},
    '{FK_GOOD,          5,  5,   2,     0,  9,  0, FILL_ONES, 1'b0},
    '{FK_GOOD,          5,  5,   2,     0, -1, 20, FILL_RAND, 1'b1},
    '{FK_GOOD,          5,  5,   2,   200, -1,  0, FILL_RAND, 1'b0},
    '{FK_GOOD,          5,  5,   1,     0, -1,  0, FILL_ONES, 1'b0},
    '{FK_GOOD,         15,  5,   4,     2, -1,  0, FILL_RAND, 1'b0}
  };

  logic clk = 1'b0;
  logic rst_n;

  s7ff_in_if  in_if();
  s7ff_out_if out_if();

  s7comm_frame_filter_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // header tracking state of the predictor
  logic [POS_W-1:0]       pos_r;
  logic [TCP_START_W-1:0] tcp_start_r;
  logic [HDR_END_W-1:0]   hdr_end_r;
  logic [BYTE_W-1:0]      cotp_len_r;
  bit                     match_r;
  bit                     at_s7_r;
  logic [BYTE_W-1:0]      type_r;
  logic [LEN_W-1:0]       plen_r;
  logic [LEN_W-1:0]       dlen_r;

  verdict_t          verdict_q[$];
  logic [BYTE_W-1:0] byte_q[$];

  bit gap_on   = 1'b1;
  bit stall_on = 1'b1;
  int err_cnt      = 0;
  int cycle_cnt    = 0;
  int sent_bytes   = 0;
  int sent_frames  = 0;
  int checked_cnt  = 0;
  int kept_cnt     = 0;

  function automatic void clear_frame_state();
    pos_r       = '0;
    tcp_start_r = '0;
    hdr_end_r   = '0;
    cotp_len_r  = '0;
    match_r     = 1'b1;
    at_s7_r     = 1'b0;
    type_r      = '0;
    plen_r      = '0;
    dlen_r      = '0;
  endfunction

  function automatic void inspect_byte(int unsigned p, logic [BYTE_W-1:0] b);
    int unsigned nib;
    int unsigned s7_at;
    if (!match_r) return;
    if (p == ETYPE_HI_POS && b != ETYPE_HI) begin
      match_r = 1'b0;
      return;
    end
    if (p == ETYPE_LO_POS && b != ETYPE_LO) begin
      match_r = 1'b0;
      return;
    end
    if (p == IHL_POS) begin
      nib = b[3:0];
      if (nib < MIN_HDR_WORDS) begin
        match_r = 1'b0;
        return;
      end
      tcp_start_r = TCP_START_W'(ETH_HDR_BYTES + nib * 4);
      return;
    end
    if (p == IP_PROTO_POS && b != IP_PROTO_TCP) begin
      match_r = 1'b0;
      return;
    end
    if (tcp_start_r != 0 && p == tcp_start_r + TCP_DOFF_OFS) begin
      nib = b[7:4];
      if (nib < MIN_HDR_WORDS) begin
        match_r = 1'b0;
        return;
      end
      hdr_end_r = HDR_END_W'(tcp_start_r + nib * 4);
      return;
    end
    if (hdr_end_r == 0) return;
    if (p == hdr_end_r) begin
      if (b != TPKT_VERSION) match_r = 1'b0;
      return;
    end
    if (p == hdr_end_r + COTP_LEN_OFS) begin
      if (b == 0) begin
        match_r = 1'b0;
        return;
      end
      cotp_len_r = b;
      return;
    end
    if (cotp_len_r == 0) return;
    s7_at = hdr_end_r + S7_ID_OFS + cotp_len_r;
    if (p == s7_at - 1) begin
      if (b != COTP_DT_FLAG) match_r = 1'b0;
      return;
    end
    if (p == s7_at) begin
      if (b != S7_PROTO_ID) begin
        match_r = 1'b0;
        return;
      end
      at_s7_r = 1'b1;
      return;
    end
    if (!at_s7_r) return;
    if (p == s7_at + S7_TYPE_OFS) type_r = b;
    else if (p == s7_at + S7_PLEN_HI_OFS) plen_r[15:8] = b;
    else if (p == s7_at + S7_PLEN_LO_OFS) plen_r[7:0] = b;
    else if (p == s7_at + S7_DLEN_HI_OFS) dlen_r[15:8] = b;
    else if (p == s7_at + S7_DLEN_LO_OFS) dlen_r[7:0] = b;
  endfunction

  // returns 1 when the word closes a frame, with its verdict
  function automatic bit predict_verdict(logic [BYTE_W-1:0] b, bit last, output verdict_t v);
    bit keep;
    v = '0;
    if (pos_r < MAX_FRAME_BYTES) inspect_byte(pos_r, b);
    if (pos_r < POS_MAX) pos_r++;
    if (!last) return 1'b0;
    keep = match_r && at_s7_r;
    if (keep) begin
      v.keep      = 1'b1;
      v.msg_type  = type_r;
      v.param_len = plen_r;
      v.dat_len   = dlen_r;
      v.s7_off    = S7_OFF_W'(hdr_end_r + S7_ID_OFS + cotp_len_r);
    end
    clear_frame_state();
    return 1'b1;
  endfunction

  function automatic logic [BYTE_W-1:0] fill_byte(fill_t fill);
    case (fill)
      FILL_ZERO: fill_byte = 8'h00;
      FILL_ONES: fill_byte = 8'hFF;
      default:   fill_byte = 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] flip_byte(logic [BYTE_W-1:0] b);
    flip_byte = b ^ 8'($urandom_range(1, 255));
  endfunction

  task automatic build_frame(frame_row_t r);
    int ip_len;
    int tcp_len;
    int s7_at;
    int i;
    logic [BYTE_W-1:0] b;
    byte_q.delete();
    if (r.kind == FK_NOISE) begin
      for (i = 0; i <= r.pad; i++) byte_q.push_back(fill_byte(r.fill));
    end else begin
      ip_len  = 4 * ((r.ihl < 5) ? 5 : r.ihl);
      tcp_len = 4 * ((r.doff < 5) ? 5 : r.doff);
      for (i = 0; i < ETYPE_HI_POS; i++) byte_q.push_back(fill_byte(r.fill));
      byte_q.push_back((r.kind == FK_BAD_ETYPE_HI) ? flip_byte(ETYPE_HI) : ETYPE_HI);
      byte_q.push_back((r.kind == FK_BAD_ETYPE_LO) ? flip_byte(ETYPE_LO) : ETYPE_LO);
      byte_q.push_back({4'h4, 4'(r.ihl)});
      for (i = 1; i < ip_len; i++) begin
        if (i == IP_PROTO_POS - IHL_POS)
          b = (r.kind == FK_NOT_TCP) ? flip_byte(IP_PROTO_TCP) : IP_PROTO_TCP;
        else
          b = fill_byte(r.fill);
        byte_q.push_back(b);
      end
      for (i = 0; i < tcp_len; i++) begin
        b = fill_byte(r.fill);
        if (i == TCP_DOFF_OFS) b[7:4] = 4'(r.doff);
        byte_q.push_back(b);
      end
      byte_q.push_back((r.kind == FK_BAD_TPKT) ? flip_byte(TPKT_VERSION) : TPKT_VERSION);
      for (i = 1; i < COTP_LEN_OFS; i++) byte_q.push_back(fill_byte(r.fill));
      byte_q.push_back((r.kind == FK_ZERO_COTP) ? 8'h00 : 8'(r.cotp));
      // cotp body, flag byte last
      for (i = 1; i <= r.cotp; i++) begin
        if (i == r.cotp)
          b = (r.kind == FK_BAD_FLAG) ? flip_byte(COTP_DT_FLAG) : COTP_DT_FLAG;
        else
          b = fill_byte(r.fill);
        byte_q.push_back(b);
      end
      s7_at = byte_q.size();
      byte_q.push_back((r.kind == FK_BAD_S7ID) ? flip_byte(S7_PROTO_ID) : S7_PROTO_ID);
      for (i = 0; i < S7_DLEN_LO_OFS + r.pad; i++) byte_q.push_back(fill_byte(r.fill));
      if (r.cut >= 0)
        while (byte_q.size() > s7_at + r.cut) void'(byte_q.pop_back());
    end
    if (r.cap > 0)
      while (byte_q.size() > r.cap) void'(byte_q.pop_back());
  endtask

  task automatic send_frame(bit typed_drop);
    int i;
    int gap;
    bit last;
    bit done;
    verdict_t v;
    for (i = 0; i < byte_q.size(); i++) begin
      gap  = gap_on ? $urandom_range(0, 14) : 0;
      last = (i == byte_q.size() - 1);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_if.valid      <= 1'b1;
      in_if.frame_byte <= byte_q[i];
      in_if.last_byte  <= last;
      @(posedge clk);
      while (in_if.ready !== 1'b1) @(posedge clk);
      done = predict_verdict(byte_q[i], last, v);
      if (done) verdict_q.push_back(typed_drop ? verdict_t'('0) : v);
      sent_bytes++;
    end
    sent_frames++;
  endtask

  task automatic wait_verdicts_drained();
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_cnt,
               verdict_q.size());
      $display("** s7comm_frame_filter_unit: FAILED **");
      $finish;
    end
  end

  initial begin : verdict_side
    int stall;
    verdict_t want;
    out_if.ready = 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = stall_on ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (out_if.valid !== 1'b1) @(posedge clk);
      checked_cnt++;
      if (verdict_q.size() == 0) begin
        $error("verdict word with none expected");
        err_cnt++;
      end else begin
        want = verdict_q.pop_front();
        if (want.keep) kept_cnt++;
        if (out_if.keep_frame !== want.keep) begin
          $error("keep_frame: expected %0d, got %0d", want.keep, out_if.keep_frame);
          err_cnt++;
        end
        if (out_if.message_type !== want.msg_type) begin
          $error("message_type: expected %0d, got %0d", want.msg_type, out_if.message_type);
          err_cnt++;
        end
        if (out_if.parameter_length !== want.param_len) begin
          $error("parameter_length: expected %0d, got %0d", want.param_len,
                 out_if.parameter_length);
          err_cnt++;
        end
        if (out_if.data_length !== want.dat_len) begin
          $error("data_length: expected %0d, got %0d", want.dat_len, out_if.data_length);
          err_cnt++;
        end
        if (out_if.s7_start_offset !== want.s7_off) begin
          $error("s7_start_offset: expected %0d, got %0d", want.s7_off,
                 out_if.s7_start_offset);
          err_cnt++;
        end
      end
    end
  end

  initial begin : frame_side
    int k;
    int pick;
    int base_bytes;
    int base_frames;
    frame_row_t r;
    in_if.valid      = 1'b0;
    in_if.frame_byte = '0;
    in_if.last_byte  = 1'b0;
    rst_n            = 1'b0;
    clear_frame_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < NUM_ROWS; k++) begin
      r = frame_rows[k];
      // the long frame goes through with no idle on either side
      gap_on   = (r.pad < 100);
      stall_on = (r.pad < 100);
      build_frame(r);
      send_frame(r.drop);
    end
    gap_on   = 1'b1;
    stall_on = 1'b1;
    in_if.valid <= 1'b0;
    wait_verdicts_drained();

    base_bytes  = sent_bytes;
    base_frames = sent_frames;
    while (sent_bytes - base_bytes < RAND_BYTES || sent_frames - base_frames < RAND_FRAMES) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) r.kind = FK_GOOD;
      else if (pick < 90) r.kind = frame_kind_t'($urandom_range(1, 9));
      else r.kind = FK_NOISE;
      r.ihl  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 6);
      r.doff = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 6);
      if (r.kind == FK_SHORT_IHL) r.ihl = $urandom_range(0, 4);
      if (r.kind == FK_SHORT_DOFF) r.doff = $urandom_range(0, 4);
      r.cotp = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 3);
      r.pad  = (r.kind == FK_NOISE) ? $urandom_range(0, 80) : $urandom_range(0, 10);
      r.cut  = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 12) : -1;
      r.cap  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 70) : 0;
      pick = $urandom_range(0, 19);
      r.fill = (pick == 0) ? FILL_ZERO : (pick == 1) ? FILL_ONES : FILL_RAND;
      r.drop = 1'b0;
      gap_on   = ($urandom_range(0, 4) != 0);
      stall_on = ($urandom_range(0, 4) != 0);
      build_frame(r);
      send_frame(1'b0);
      // every so often let the verdict side catch up completely
      if (sent_frames % 16 == 0) begin
        in_if.valid <= 1'b0;
        wait_verdicts_drained();
      end
    end

    in_if.valid <= 1'b0;
    wait_verdicts_drained();
    repeat (16) @(posedge clk);
    $display("sent %0d frames (%0d bytes): table rows, random S7, broken and noise frames",
             sent_frames, sent_bytes);
    $display("checked %0d verdicts, %0d kept, %0d mismatches", checked_cnt, kept_cnt,
             err_cnt);
    if (err_cnt == 0) begin
      $display("** s7comm_frame_filter_unit: PASSED **");
    end else begin
      $display("** s7comm_frame_filter_unit: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/s7ff_pkg.sv
rtl/core/s7ff_in_if.sv
rtl/core/s7ff_out_if.sv
rtl/core/s7comm_frame_filter_unit.sv
tb/tb.sv
